// ----- hdl/bce_pkg.sv -----
`default_nettype none
package bce_pkg;

  localparam int unsigned PredW    = 32;
  localparam int unsigned TargW    = 17;
  localparam int unsigned MeanW    = 21;
  localparam int unsigned LenW     = 11;
  localparam int unsigned CountW   = 10;
  localparam int unsigned SumW     = 31;
  localparam int unsigned LossW    = 22;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = 2;

  localparam logic [PredW-1:0]  PLo       = 32'd429;
  localparam logic [PredW-1:0]  PHi       = 32'd4294966867;
  localparam logic [TargW-1:0]  OneQ16    = 17'd65536;
  localparam logic [15:0]       Ln2Q16    = 16'd45426;
  localparam logic [LenW-1:0]   MaxRowLen = 11'd1024;
  localparam logic [MeanW-1:0]  MeanMax   = '1;
  localparam logic [SumW-1:0]   SumMax    = '1;

  // queue fill status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // ln(1 + i/32) in q.16
  function automatic logic [15:0] ln_tab(input logic [5:0] i);
    logic [15:0] v;
    begin
      case (i)
        6'd0:  v = 16'd0;     6'd1:  v = 16'd2017;  6'd2:  v = 16'd3973;
        6'd3:  v = 16'd5873;  6'd4:  v = 16'd7719;  6'd5:  v = 16'd9515;
        6'd6:  v = 16'd11262; 6'd7:  v = 16'd12965; 6'd8:  v = 16'd14624;
        6'd9:  v = 16'd16242; 6'd10: v = 16'd17821; 6'd11: v = 16'd19364;
        6'd12: v = 16'd20870; 6'd13: v = 16'd22343; 6'd14: v = 16'd23783;
        6'd15: v = 16'd25193; 6'd16: v = 16'd26573; 6'd17: v = 16'd27924;
        6'd18: v = 16'd29248; 6'd19: v = 16'd30546; 6'd20: v = 16'd31818;
        6'd21: v = 16'd33067; 6'd22: v = 16'd34292; 6'd23: v = 16'd35494;
        6'd24: v = 16'd36675; 6'd25: v = 16'd37835; 6'd26: v = 16'd38975;
        6'd27: v = 16'd40095; 6'd28: v = 16'd41196; 6'd29: v = 16'd42280;
        6'd30: v = 16'd43345; 6'd31: v = 16'd44394; 6'd32: v = 16'd45426;
        default: v = 16'd0;
      endcase
      return v;
    end
  endfunction

  // index of the top set bit
  function automatic logic [4:0] top_bit(input logic [PredW-1:0] x);
    logic [4:0] k;
    begin
      k = '0;
      for (int i = 0; i < PredW; i++) begin
        if (x[i]) k = 5'(i);
      end
      return k;
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/bce_front.sv -----
`default_nettype none
module bce_front
  import bce_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [PredW-1:0] prediction_i,
  input  wire logic [TargW-1:0] target_i,
  input  wire q_stat_t          q_stat_i,
  output logic                  push_o,
  output logic [LossW-1:0]      push_loss_o
);

  typedef enum logic [5:0] {
    F_IDLE   = 6'b000001,
    F_NORM   = 6'b000010,
    F_INTERP = 6'b000100,
    F_LN     = 6'b001000,
    F_MUL    = 6'b010000,
    F_PUSH   = 6'b100000
  } f_state_e;

  f_state_e state_q, state_d;

  logic [PredW-1:0] p_q, c_q;
  logic [TargW-1:0] t_q;
  logic [4:0]  kp_q, kc_q;
  logic [4:0]  ip_q, ic_q;
  logic [15:0] fp_q, fc_q;
  logic [15:0] lop_q, loc_q;
  logic [26:0] prp_q, prc_q;
  logic [LossW-1:0] a_q, b_q;
  logic [38:0] ta_q, tb_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE:   if (in_valid_i) state_d = F_NORM;
      F_NORM:   state_d = F_INTERP;
      F_INTERP: state_d = F_LN;
      F_LN:     state_d = F_MUL;
      F_MUL:    state_d = F_PUSH;
      F_PUSH:   if (!q_stat_i.full) state_d = F_IDLE;
      default:  state_d = F_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == F_IDLE);

  // datapath
  logic [PredW-1:0] p_clip;
  logic [PredW-1:0] yp, yc;
  logic [4:0]  kp, kc;
  logic [15:0] hip, hic;
  logic [15:0] lnmp, lnmc;
  logic [21:0] basep, basec;
  logic [39:0] lsum;

  always_comb begin
    p_clip = prediction_i;
    if (p_clip < PLo) p_clip = PLo;
    if (p_clip > PHi) p_clip = PHi;
    kp = top_bit(p_q);
    kc = top_bit(c_q);
    yp = p_q << (5'd31 - kp);
    yc = c_q << (5'd31 - kc);
    hip = ln_tab({1'b0, ip_q} + 6'd1);
    hic = ln_tab({1'b0, ic_q} + 6'd1);
    lnmp = lop_q + 16'((prp_q + 27'd32768) >> 16);
    lnmc = loc_q + 16'((prc_q + 27'd32768) >> 16);
    basep = {15'b0, ({1'b0, 6'd32} - {2'b0, kp_q})} * {6'b0, Ln2Q16};
    basec = {15'b0, ({1'b0, 6'd32} - {2'b0, kc_q})} * {6'b0, Ln2Q16};
    lsum = {1'b0, ta_q} + {1'b0, tb_q} + 40'd32768;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      p_q <= p_clip;
      c_q <= 32'(33'h1_0000_0000 - {1'b0, p_clip});
      t_q <= (target_i > OneQ16) ? OneQ16 : target_i;
    end
    if (state_q == F_NORM) begin
      kp_q <= kp;
      kc_q <= kc;
      ip_q <= yp[30:26];
      ic_q <= yc[30:26];
      fp_q <= yp[25:10];
      fc_q <= yc[25:10];
    end
    if (state_q == F_INTERP) begin
      lop_q <= ln_tab({1'b0, ip_q});
      loc_q <= ln_tab({1'b0, ic_q});
      prp_q <= {11'b0, hip - ln_tab({1'b0, ip_q})} * {11'b0, fp_q};
      prc_q <= {11'b0, hic - ln_tab({1'b0, ic_q})} * {11'b0, fc_q};
    end
    if (state_q == F_LN) begin
      a_q <= basep - {6'b0, lnmp};
      b_q <= basec - {6'b0, lnmc};
    end
    if (state_q == F_MUL) begin
      ta_q <= t_q * a_q;
      tb_q <= (OneQ16 - t_q) * b_q;
    end
  end

  assign push_o      = (state_q == F_PUSH) && !q_stat_i.full;
  assign push_loss_o = lsum[37:16];

endmodule
`default_nettype wire

// ----- hdl/bce_queue.sv -----
`default_nettype none
module bce_queue
  import bce_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [LossW-1:0] push_loss_i,
  output q_stat_t               q_stat_o,
  input  wire logic             pop_i,
  output logic [LossW-1:0]      pop_loss_o
);

  logic [LossW-1:0] mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_loss_i;
  end

  assign pop_loss_o     = mem_q[rd_q];
  assign q_stat_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign q_stat_o.empty = (cnt_q == '0);

endmodule
`default_nettype wire

// ----- hdl/bce_back.sv -----
`default_nettype none
module bce_back
  import bce_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [LenW-1:0]  row_len_i,
  input  wire logic             q_empty_i,
  input  wire logic [LossW-1:0] q_loss_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [MeanW-1:0]      row_mean_loss_o
);

  typedef enum logic [2:0] {
    B_ACC  = 3'b001,
    B_DIV  = 3'b010,
    B_LOAD = 3'b100
  } b_state_e;

  b_state_e state_q, state_d;

  logic [CountW-1:0] count_q;
  logic [SumW-1:0]   sum_q;
  logic [31:0]       dvd_q;
  logic [LenW-1:0]   rem_q;
  logic [LenW-1:0]   len_q;
  logic [4:0]        step_q;
  logic              ovalid_q;
  logic [MeanW-1:0]  mean_q;

  // effective row length
  logic [LenW-1:0] len;
  always_comb begin
    len = row_len_i;
    if (len == '0) len = 11'd1;
    if (len > MaxRowLen) len = MaxRowLen;
  end

  logic [SumW:0]   sum_add;
  logic [SumW-1:0] sum_new;
  logic            row_end;
  logic [LenW:0]   rem_sh;
  logic            take;

  always_comb begin
    sum_add = {1'b0, sum_q} + {10'b0, q_loss_i};
    sum_new = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
    row_end = ({1'b0, count_q} + 11'd1) >= len;
    rem_sh  = {rem_q, dvd_q[31]};
    take    = rem_sh >= {1'b0, len_q};
    pop_o   = (state_q == B_ACC) && !q_empty_i;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_ACC:   if (pop_o && row_end) state_d = B_DIV;
      B_DIV:   if (step_q == 5'd31) state_d = B_LOAD;
      B_LOAD:  if (!ovalid_q || out_ready_i) state_d = B_ACC;
      default: state_d = B_ACC;
    endcase
  end

  // control and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_ACC;
      count_q  <= '0;
      sum_q    <= '0;
      step_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        if (row_end) begin
          count_q <= '0;
          sum_q   <= '0;
        end else begin
          count_q <= count_q + 1'b1;
          sum_q   <= sum_new;
        end
      end
      if (state_q == B_DIV) step_q <= step_q + 1'b1;
      else step_q <= '0;
      if (state_q == B_LOAD && (!ovalid_q || out_ready_i)) ovalid_q <= 1'b1;
      else if (out_ready_i) ovalid_q <= 1'b0;
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (pop_o && row_end) begin
      dvd_q <= {1'b0, sum_new} + {22'b0, len[LenW-1:1]};
      rem_q <= '0;
      len_q <= len;
    end else if (state_q == B_DIV) begin
      dvd_q <= {dvd_q[30:0], take};
      rem_q <= take ? LenW'(rem_sh - {1'b0, len_q}) : rem_sh[LenW-1:0];
    end
    if (state_q == B_LOAD && (!ovalid_q || out_ready_i)) begin
      mean_q <= (dvd_q[31:MeanW] != '0) ? MeanMax : dvd_q[MeanW-1:0];
    end
  end

  assign out_valid_o     = ovalid_q;
  assign row_mean_loss_o = mean_q;

endmodule
`default_nettype wire

// ----- hdl/binary_cross_entropy_row_loss_unit.sv -----
// Binary cross-entropy row loss.
// Input channel (in_valid_i/in_ready_o) takes one prediction (q0.32) and
// target (q1.16) request at a time. The front clips, takes both logs by
// table interpolation and forms the element loss through its NORM,
// INTERP, LN, MUL and PUSH states; the front FSM takes no new element
// until it has pushed the last one. Element losses go through a
// four-entry queue to the back, which adds them into a saturating row
// sum. At the last element of a row the back runs a restoring divide
// for the rounded mean, then loads the output register. While a divide
// runs, the front keeps working until the queue fills. If the receiver
// stalls out_ready_i low, the result holds and the next row can still
// accumulate up to its own end.
// The config channel (cfg_valid_i/cfg_ready_o) writes row_length, always
// ready; write it only while idle. Reset sets row_length to 1 and clears
// the row count, sum, queue and output valid.
`default_nettype none
module binary_cross_entropy_row_loss_unit
  import bce_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [LenW-1:0]  cfg_row_length_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [PredW-1:0] prediction_i,
  input  wire logic [TargW-1:0] target_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [MeanW-1:0]      row_mean_loss_o
);

  logic [LenW-1:0] row_len_q;
  q_stat_t         q_stat;
  logic            push, pop;
  logic [LossW-1:0] push_loss, pop_loss;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= 11'd1;
    end else if (cfg_valid_i) begin
      row_len_q <= cfg_row_length_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  bce_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .prediction_i, .target_i,
    .q_stat_i(q_stat), .push_o(push), .push_loss_o(push_loss)
  );

  bce_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_loss_i(push_loss),
    .q_stat_o(q_stat), .pop_i(pop), .pop_loss_o(pop_loss)
  );

  bce_back u_back (
    .clk_i, .rst_ni, .row_len_i(row_len_q), .q_empty_i(q_stat.empty),
    .q_loss_i(pop_loss), .pop_o(pop), .out_valid_o, .out_ready_i,
    .row_mean_loss_o
  );

endmodule
`default_nettype wire

// ----- tb/tb_binary_cross_entropy_row_loss_unit.sv -----
`timescale 1ns / 100ps
module tb_binary_cross_entropy_row_loss_unit;
  import bce_pkg::*;

  typedef struct packed {
    logic [PredW-1:0] pred;
    logic [TargW-1:0] targ;
  } element_t;

  localparam int unsigned LnTab [33] = '{
    0, 2017, 3973, 5873, 7719, 9515, 11262, 12965,
    14624, 16242, 17821, 19364, 20870, 22343, 23783, 25193,
    26573, 27924, 29248, 30546, 31818, 33067, 34292, 35494,
    36675, 37835, 38975, 40095, 41196, 42280, 43345, 44394,
    45426};
  localparam int SettleCycles = 80;
  localparam int StallLimit   = 5000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [LenW-1:0]  cfg_row_length_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  logic [PredW-1:0] prediction_i = '0;
  logic [TargW-1:0] target_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [MeanW-1:0] row_mean_loss_o;

  binary_cross_entropy_row_loss_unit dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_row_length_i,
    .in_valid_i, .in_ready_o, .prediction_i, .target_i,
    .out_valid_o, .out_ready_i, .row_mean_loss_o
  );

  always #6 clk_i = ~clk_i;

  element_t         pending_elems [$];
  logic [MeanW-1:0] mean_q [$];
  bit               quiet = 1'b0;
  int               errors = 0;
  int               n_elems = 0;
  int               n_rows = 0;
  int               n_cfg = 0;

  // model state of the row accumulator
  logic [LenW-1:0]   row_len_m = 11'd1;
  logic [CountW-1:0] count_m = '0;
  logic [SumW-1:0]   sum_m = '0;

  // -ln(x / 2^32) in q.16
  function automatic longint unsigned neg_ln_q16(input logic [31:0] x);
    int k;
    logic [31:0] y;
    int unsigned idx, f;
    longint unsigned lnm;
    k = 31;
    if (x == 0) x = 1;
    while (!x[k]) k--;
    y = x << (31 - k);
    idx = y[30:26];
    f = y[25:10];
    lnm = LnTab[idx] + (((LnTab[idx+1] - LnTab[idx]) * longint'(f) + 32768) >> 16);
    return longint'(32 - k) * 45426 - lnm;
  endfunction

  // clip, take both logs, accumulate; push a mean at the end of a row
  task automatic predict_row_loss(input element_t e);
    logic [31:0] p;
    longint unsigned t, len, loss, acc;
    p = e.pred;
    t = (e.targ > 65536) ? 65536 : e.targ;
    len = (row_len_m == 0) ? 1 : (row_len_m > 1024) ? 1024 : row_len_m;
    if (p < 32'd429) p = 32'd429;
    if (p > 32'd4294966867) p = 32'd4294966867;
    loss = (t * neg_ln_q16(p) + (65536 - t) * neg_ln_q16(32'd0 - p) + 32768) >> 16;
    acc = sum_m + loss;
    sum_m = (acc > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : acc[SumW-1:0];
    if (count_m + 1 >= len) begin
      acc = (sum_m + (len >> 1)) / len;
      mean_q.push_back((acc > 64'h1F_FFFF) ? 21'h1F_FFFF : acc[MeanW-1:0]);
      count_m = '0;
      sum_m = '0;
    end else begin
      count_m = count_m + 1'b1;
    end
  endtask

  // request driver with random gaps
  int in_gap = 0;
  always @(posedge clk_i) begin
    element_t e;
    if (!in_valid_i || in_ready_o) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_elems.size() > 0) begin
        e = pending_elems.pop_front();
        prediction_i <= e.pred;
        target_i <= e.targ;
        in_valid_i <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 15);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  int out_stall = 0;
  always @(posedge clk_i) begin
    if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) out_stall = $urandom_range(1, 15);
    end
  end

  // monitor: predict on accepted requests, check accepted results
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    logic [MeanW-1:0] want;
    bit handshake;
    if (rst_ni) begin
      handshake = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        row_len_m = cfg_row_length_i;
        handshake = 1'b1;
      end
      if (in_valid_i && in_ready_o) begin
        predict_row_loss('{pred: prediction_i, targ: target_i});
        n_elems++;
        handshake = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        handshake = 1'b1;
        n_rows++;
        if (mean_q.size() == 0) begin
          $display("%0t: unexpected row mean, expected none, actual %0d",
                   $realtime, row_mean_loss_o);
          errors++;
        end else begin
          want = mean_q.pop_front();
          if (want !== row_mean_loss_o) begin
            $display("%0t: row_mean_loss mismatch, expected %0d, actual %0d",
                     $realtime, want, row_mean_loss_o);
            errors++;
          end
        end
      end
      idle_cycles <= handshake ? 0 : idle_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (idle_cycles >= StallLimit) begin
      $display("timeout after %0d cycles without a handshake", StallLimit);
      $display("binary_cross_entropy_row_loss_unit test failed");
      $finish;
    end
  end

  task automatic write_row_length(input logic [LenW-1:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_row_length_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_cfg++;
  endtask

  task automatic wait_drained();
    wait (pending_elems.size() == 0 && !in_valid_i && mean_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic element_t rand_element();
    element_t e;
    case ($urandom_range(0, 5))
      0: e.pred = $urandom_range(0, 1023);
      1: e.pred = 32'hFFFF_FFFF - $urandom_range(0, 1023);
      2: e.pred = $urandom() >> $urandom_range(0, 31);
      default: e.pred = $urandom();
    endcase
    case ($urandom_range(0, 7))
      0: e.targ = 17'd0;
      1: e.targ = 17'd65536;
      2: e.targ = $urandom_range(65537, 131071);
      default: e.targ = $urandom_range(0, 65536);
    endcase
    return e;
  endfunction

  initial begin
    logic [31:0] preds [8];
    logic [TargW-1:0] targs [5];
    int total;
    int len;
    int cnt;
    bit long_done;
    preds = '{32'd0, 32'd1, 32'd428, 32'd429, 32'd430, 32'h8000_0000,
              32'd4294966867, 32'hFFFF_FFFF};
    targs = '{17'd0, 17'd32768, 17'd65536, 17'd65537, 17'h1FFFF};
    total = 0;
    long_done = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // field extremes at the reset length of one
    for (int i = 0; i < 8; i++) begin
      pending_elems.push_back('{pred: preds[i], targ: targs[i % 5]});
    end
    pending_elems.push_back('{pred: 32'h0000_FFFF, targ: 17'd65537});
    pending_elems.push_back('{pred: 32'hFFFF_0000, targ: 17'h1FFFF});
    total += 10;
    wait_drained();

    // zero length acts as one, oversize length acts as the maximum
    write_row_length(11'd0);
    for (int i = 0; i < 3; i++) pending_elems.push_back(rand_element());
    total += 3;
    wait_drained();
    write_row_length(11'h7FF);
    for (int i = 0; i < 1024; i++) pending_elems.push_back(rand_element());
    total += 1024;
    long_done = 1'b1;
    wait_drained();

    // length shortened mid-row ends the row early
    write_row_length(11'd5);
    for (int i = 0; i < 3; i++) pending_elems.push_back(rand_element());
    total += 3;
    wait_drained();
    write_row_length(11'd2);
    for (int i = 0; i < 2; i++) pending_elems.push_back(rand_element());
    total += 2;
    wait_drained();

    // random rows, mostly short; an oversize length gets one to three elements
    while (total < 1450) begin
      if (total > 1150) quiet = 1'b1;
      if (!long_done && $urandom_range(0, 15) == 0) begin
        len = 1024;
        long_done = 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        len = $urandom_range(1025, 2047);
      end else begin
        len = $urandom_range(0, 12);
      end
      write_row_length(len[LenW-1:0]);
      cnt = (len >= 1024) ? 1024 : $urandom_range(1, 40);
      if (len > 1024) cnt = $urandom_range(1, 3);
      for (int i = 0; i < cnt; i++) pending_elems.push_back(rand_element());
      total += cnt;
      wait_drained();
    end

    $display("covered %0d elements, %0d row means, %0d row length writes",
             n_elems, n_rows, n_cfg);
    if (errors == 0 && mean_q.size() == 0) begin
      $display("binary_cross_entropy_row_loss_unit test passed");
    end else begin
      $display("binary_cross_entropy_row_loss_unit test failed");
    end
    $finish;
  end

endmodule
